// File: design/gyro_calibrate_and_integrate_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the gyro calibration and integration block
// Each check fires on the rising edge of clk. The plain form is disabled
// while rst_n is low. The reset form also runs during reset.
// ---------------------------------------------------------------------------
`ifndef GYRO_CALIBRATE_AND_INTEGRATE_TOP_MACROS_SVH
`define GYRO_CALIBRATE_AND_INTEGRATE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Property checked outside reset.
`define GCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define GCI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GCI_ASSERT(lbl, prop, msg)
`define GCI_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: design/gci_pkg.sv
// ---------------------------------------------------------------------------
// gci_pkg: shared types and constants
// Field widths, register codes, reset values and the pipeline item types
// of the gyro calibration and integration block.
// ---------------------------------------------------------------------------
package gci_pkg;

  // Field widths.
  localparam int ACC_W     = 16;
  localparam int RATE_W    = 16;
  localparam int DT_W      = 16;
  localparam int SUM_W     = 24;
  localparam int BIAS_W    = 16;
  localparam int ANGLE_W   = 48;
  localparam int MAG_W     = 32;
  localparam int STILL_W   = 28;
  localparam int THR_W     = 47;
  localparam int SNAP_W    = 2;
  localparam int CFG_W     = 47;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 8;
  localparam int AXES      = 3;

  // Number of still samples in one calibration run.
  localparam int CAL_SAMPLES = 200;

  // Reciprocal for the division of a sum magnitude by CAL_SAMPLES.
  // The magnitude stays below 2^23, so the rounding error of the
  // reciprocal stays below one part in 2^DIV_SHIFT and the quotient is exact.
  localparam int DIV_SHIFT = 31;
  localparam int QUOT_W    = BIAS_W + 1;
  localparam int DIV_PROD_W = SUM_W + 32;
  localparam logic [31:0] DIV_MULT =
      32'(((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_STILL_MIN_SQ    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_MAX_SQ    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_THRESHOLD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_THRESHOLD = 2'd3;

  // Register reset values.
  localparam logic [STILL_W-1:0] STILL_MIN_SQ_RST    = 28'd16443349;
  localparam logic [STILL_W-1:0] STILL_MAX_SQ_RST    = 28'd17114438;
  localparam logic [THR_W-1:0]   ZERO_THRESHOLD_RST  = 47'd640000000;
  localparam logic [THR_W-1:0]   RIGHT_THRESHOLD_RST = 47'd800000000;

  // Snapped angle codes.
  localparam logic [SNAP_W-1:0] SNAP_ZERO = 2'b00;
  localparam logic [SNAP_W-1:0] SNAP_POS  = 2'b01;
  localparam logic [SNAP_W-1:0] SNAP_NEG  = 2'b11;

  // Registered input item with its squared acceleration magnitude.
  typedef struct packed {
    logic [AXES-1:0][RATE_W-1:0] rate;
    logic [DT_W-1:0]             elapsed_us;
    logic                        restart_cal;
    logic [MAG_W-1:0]            mag_sq;
  } sample_t;

  // Status flags carried with every result.
  typedef struct packed {
    logic calibrating;
    logic motion_fault;
    logic cal_done;
  } status_t;

  // State after one item: flags and full angles.
  typedef struct packed {
    status_t                      status;
    logic [AXES-1:0][ANGLE_W-1:0] angle;
  } update_t;

  // Result item: flags and snapped angles.
  typedef struct packed {
    status_t                     status;
    logic [AXES-1:0][SNAP_W-1:0] snap;
  } result_t;

endpackage

// File: design/gci_sample_stage.sv
// ---------------------------------------------------------------------------
// gci_sample_stage: input register
// Registers an accepted item together with the squared magnitude of its
// acceleration vector.
// ---------------------------------------------------------------------------
module gci_sample_stage (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          up_valid,
  output logic                                          up_ready,
  input  logic [gci_pkg::AXES-1:0][gci_pkg::ACC_W-1:0]  accel,
  input  logic [gci_pkg::AXES-1:0][gci_pkg::RATE_W-1:0] rate,
  input  logic [gci_pkg::DT_W-1:0]                      elapsed_us,
  input  logic                                          restart_cal,
  input  logic                                          down_ready,
  output logic                                          valid_o,
  output gci_pkg::sample_t                              sample_o
);

  logic             valid_r;
  logic             valid_nxt;
  gci_pkg::sample_t sample_r;
  logic [gci_pkg::MAG_W-1:0] mag_sq;
  logic             load;

  // The stage takes an item when it is empty or its item moves on.
  assign up_ready = !valid_r || down_ready;
  assign load     = up_valid && up_ready;

  // Sum of the three squared accelerations; it stays below 2^32.
  always_comb begin
    logic signed [gci_pkg::MAG_W-1:0] sq;
    mag_sq = '0;
    for (int i = 0; i < gci_pkg::AXES; i++) begin
      sq     = $signed(accel[i]) * $signed(accel[i]);
      mag_sq = mag_sq + gci_pkg::MAG_W'(unsigned'(sq));
    end
  end

  assign valid_nxt = load ? 1'b1 : (down_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      sample_r.rate        <= rate;
      sample_r.elapsed_us  <= elapsed_us;
      sample_r.restart_cal <= restart_cal;
      sample_r.mag_sq      <= mag_sq;
    end
  end

  assign valid_o  = valid_r;
  assign sample_o = sample_r;

endmodule

// File: design/gci_update_stage.sv
// ---------------------------------------------------------------------------
// gci_update_stage: calibration and integration state
// Holds the calibration mode, still count, rate sums, biases and angles,
// updates them once per item and registers the new angles and flags.
// ---------------------------------------------------------------------------
`include "gyro_calibrate_and_integrate_top_macros.svh"

module gci_update_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  gci_pkg::sample_t               sample_i,
  input  logic [gci_pkg::STILL_W-1:0]    still_min_sq,
  input  logic [gci_pkg::STILL_W-1:0]    still_max_sq,
  input  logic                           down_ready,
  output logic                           valid_o,
  output gci_pkg::update_t               update_o
);

  localparam int SUM_W   = gci_pkg::SUM_W;
  localparam int BIAS_W  = gci_pkg::BIAS_W;
  localparam int ANGLE_W = gci_pkg::ANGLE_W;
  localparam int QUOT_W  = gci_pkg::QUOT_W;
  localparam int PROD_W  = gci_pkg::BIAS_W + gci_pkg::DT_W + 2;
  localparam int DIFF_W  = gci_pkg::BIAS_W + 1;

  logic                        cal_mode_r, cal_mode_nxt;
  logic [gci_pkg::CNT_W-1:0]   still_count_r, still_count_nxt;
  logic [SUM_W-1:0]            rate_sum_r [gci_pkg::AXES];
  logic [SUM_W-1:0]            rate_sum_nxt [gci_pkg::AXES];
  logic [BIAS_W-1:0]           bias_r [gci_pkg::AXES];
  logic [BIAS_W-1:0]           bias_nxt [gci_pkg::AXES];
  logic [ANGLE_W-1:0]          angle_r [gci_pkg::AXES];
  logic [ANGLE_W-1:0]          angle_nxt [gci_pkg::AXES];
  logic                        valid_r, valid_nxt;
  gci_pkg::update_t            update_r, update_nxt;

  logic                        load;
  logic                        in_band;
  logic [gci_pkg::CNT_W:0]     count_inc;
  logic                        reach;
  logic [SUM_W-1:0]            sum_add [gci_pkg::AXES];
  logic [BIAS_W-1:0]           bias_div [gci_pkg::AXES];
  logic [ANGLE_W-1:0]          angle_int [gci_pkg::AXES];

  assign up_ready = !valid_r || down_ready;
  assign load     = up_valid && up_ready;

  // Stillness check and still count.
  assign in_band   = (sample_i.mag_sq > gci_pkg::MAG_W'(still_min_sq)) &&
                     (sample_i.mag_sq < gci_pkg::MAG_W'(still_max_sq));
  assign count_inc = {1'b0, still_count_r} + 1'b1;
  assign reach     = count_inc >= (gci_pkg::CNT_W + 1)'(gci_pkg::CAL_SAMPLES);

  // Per-axis arithmetic: rate sum, bias quotient and integrated angle.
  always_comb begin
    logic [SUM_W-1:0]              mag;
    logic [gci_pkg::DIV_PROD_W-1:0] q_full;
    logic [QUOT_W-1:0]             quot;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [PROD_W-1:0]      prod;
    logic signed [ANGLE_W:0]       sum;
    for (int i = 0; i < gci_pkg::AXES; i++) begin
      sum_add[i] = rate_sum_r[i] +
                   {{(SUM_W - gci_pkg::RATE_W){sample_i.rate[i][gci_pkg::RATE_W-1]}},
                    sample_i.rate[i]};

      // Division toward zero: divide the magnitude, then restore the sign.
      mag    = sum_add[i][SUM_W-1] ? (~sum_add[i] + 1'b1) : sum_add[i];
      q_full = gci_pkg::DIV_PROD_W'(mag) * gci_pkg::DIV_PROD_W'(gci_pkg::DIV_MULT);
      quot   = q_full[gci_pkg::DIV_SHIFT +: QUOT_W];
      if (sum_add[i][SUM_W-1]) begin
        quot = ~quot + 1'b1;
      end
      bias_div[i] = quot[BIAS_W-1:0];

      // Angle step with saturation to the signed angle range.
      diff = $signed({sample_i.rate[i][gci_pkg::RATE_W-1], sample_i.rate[i]}) -
             $signed({bias_r[i][BIAS_W-1], bias_r[i]});
      prod = diff * $signed({1'b0, sample_i.elapsed_us});
      sum  = $signed({angle_r[i][ANGLE_W-1], angle_r[i]}) +
             $signed({{(ANGLE_W + 1 - PROD_W){prod[PROD_W-1]}}, prod});
      if (sum[ANGLE_W] != sum[ANGLE_W-1]) begin
        angle_int[i] = sum[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                    : {1'b0, {(ANGLE_W-1){1'b1}}};
      end else begin
        angle_int[i] = sum[ANGLE_W-1:0];
      end
    end
  end

  // Next state and result.
  always_comb begin
    cal_mode_nxt    = cal_mode_r;
    still_count_nxt = still_count_r;
    rate_sum_nxt    = rate_sum_r;
    bias_nxt        = bias_r;
    angle_nxt       = angle_r;
    update_nxt      = update_r;
    if (load) begin
      update_nxt.status.motion_fault = 1'b0;
      update_nxt.status.cal_done     = 1'b0;
      priority if (sample_i.restart_cal) begin
        cal_mode_nxt    = 1'b1;
        still_count_nxt = '0;
        for (int i = 0; i < gci_pkg::AXES; i++) begin
          rate_sum_nxt[i] = '0;
          angle_nxt[i]    = '0;
        end
      end else if (cal_mode_r && !in_band) begin
        // Movement while calibrating: start over and report it.
        cal_mode_nxt    = 1'b1;
        still_count_nxt = '0;
        for (int i = 0; i < gci_pkg::AXES; i++) begin
          rate_sum_nxt[i] = '0;
          angle_nxt[i]    = '0;
        end
        update_nxt.status.motion_fault = 1'b1;
      end else if (cal_mode_r) begin
        rate_sum_nxt    = sum_add;
        still_count_nxt = count_inc[gci_pkg::CNT_W-1:0];
        if (reach) begin
          bias_nxt     = bias_div;
          cal_mode_nxt = 1'b0;
          for (int i = 0; i < gci_pkg::AXES; i++) begin
            angle_nxt[i] = '0;
          end
          update_nxt.status.cal_done = 1'b1;
        end
      end else begin
        angle_nxt = angle_int;
      end
      update_nxt.status.calibrating = cal_mode_nxt;
      for (int i = 0; i < gci_pkg::AXES; i++) begin
        update_nxt.angle[i] = angle_nxt[i];
      end
    end
  end

  assign valid_nxt = load ? 1'b1 : (down_ready ? 1'b0 : valid_r);

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= 1'b0;
      cal_mode_r    <= 1'b1;
      still_count_r <= '0;
      for (int i = 0; i < gci_pkg::AXES; i++) begin
        rate_sum_r[i] <= '0;
        bias_r[i]     <= '0;
        angle_r[i]    <= '0;
      end
    end else begin
      valid_r       <= valid_nxt;
      cal_mode_r    <= cal_mode_nxt;
      still_count_r <= still_count_nxt;
      rate_sum_r    <= rate_sum_nxt;
      bias_r        <= bias_nxt;
      angle_r       <= angle_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    update_r <= update_nxt;
  end

  assign valid_o  = valid_r;
  assign update_o = update_r;

  // Checks on the calibration sequence.
  `GCI_ASSERT(a_done_leaves_cal, (load && reach && cal_mode_r && in_band && !sample_i.restart_cal) |=> !cal_mode_r, "completed calibration did not leave calibration mode")
  `GCI_ASSERT(a_fault_not_done, valid_r |-> !(update_r.status.motion_fault && update_r.status.cal_done), "motion fault and calibration done in one result")
  `GCI_ASSERT(a_count_bound, still_count_r <= gci_pkg::CNT_W'(gci_pkg::CAL_SAMPLES), "still count beyond calibration length")
  `GCI_ASSERT(a_restart_clears, (load && sample_i.restart_cal) |=> (angle_r[0] == '0 && angle_r[1] == '0 && angle_r[2] == '0 && cal_mode_r), "restart did not clear the angles")

endmodule

// File: design/gci_snap_stage.sv
// ---------------------------------------------------------------------------
// gci_snap_stage: angle snapping and result register
// Rounds each angle to zero or a signed right angle and holds the result
// item until the downstream side takes it.
// ---------------------------------------------------------------------------
module gci_snap_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  gci_pkg::update_t            update_i,
  input  logic [gci_pkg::THR_W-1:0]   zero_threshold,
  input  logic [gci_pkg::THR_W-1:0]   right_angle_threshold,
  input  logic                        down_ready,
  output logic                        valid_o,
  output gci_pkg::result_t            result_o
);

  logic             valid_r, valid_nxt;
  gci_pkg::result_t result_r;
  gci_pkg::result_t result_nxt;
  logic             load;

  // Snap one angle: |a| < zero_thr gives zero, else |a| > right_thr the sign, else zero.
  function automatic logic [gci_pkg::SNAP_W-1:0] snap_angle(
    input logic [gci_pkg::ANGLE_W-1:0] a,
    input logic [gci_pkg::THR_W-1:0]   zero_thr,
    input logic [gci_pkg::THR_W-1:0]   right_thr
  );
    logic [gci_pkg::ANGLE_W-1:0] mag;
    logic [gci_pkg::SNAP_W-1:0]  code;
    mag = a[gci_pkg::ANGLE_W-1] ? (~a + 1'b1) : a;
    priority if (mag < {1'b0, zero_thr}) begin
      code = gci_pkg::SNAP_ZERO;
    end else if (mag > {1'b0, right_thr}) begin
      code = a[gci_pkg::ANGLE_W-1] ? gci_pkg::SNAP_NEG : gci_pkg::SNAP_POS;
    end else begin
      code = gci_pkg::SNAP_ZERO;
    end
    return code;
  endfunction

  assign up_ready = !valid_r || down_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    result_nxt.status = update_i.status;
    for (int i = 0; i < gci_pkg::AXES; i++) begin
      result_nxt.snap[i] = snap_angle(update_i.angle[i], zero_threshold,
                                      right_angle_threshold);
    end
  end

  assign valid_nxt = load ? 1'b1 : (down_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_nxt;
    end
  end

  assign valid_o  = valid_r;
  assign result_o = result_r;

endmodule

// File: design/gyro_calibrate_and_integrate_top.sv
// ---------------------------------------------------------------------------
// gyro_calibrate_and_integrate_top: gyro bias calibration and integration
// Calibrates the rate biases on still samples, then integrates the
// bias-corrected rates into three angles and reports them snapped.
// ---------------------------------------------------------------------------
// The block takes one sample item per clock cycle and returns one result
// item for each through its registers in turn: an input register that
// also forms the squared acceleration magnitude, an update register that
// holds the calibration and angle state, and a result register that holds
// the snapped angles. The state update for one item, including the
// rate-times-time product and the bias division by a reciprocal multiply,
// is combinational, so items follow each other without gaps; only a
// stalled result side holds the pipeline.
module gyro_calibrate_and_integrate_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input items.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, elapsed_us
  input  logic [111:0]                    in_tdata,
  // restart_cal
  input  logic                            in_tuser,
  // Result items.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // snap_x, snap_y, snap_z, two zero bits
  output logic [7:0]                      out_tdata,
  // calibrating, motion_fault, cal_done
  output logic [2:0]                      out_tuser,
  // Configuration writes.
  input  logic                            cfg_we,
  input  logic [gci_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gci_pkg::CFG_W-1:0]       cfg_data
);

  logic [gci_pkg::STILL_W-1:0] still_min_sq_r;
  logic [gci_pkg::STILL_W-1:0] still_max_sq_r;
  logic [gci_pkg::THR_W-1:0]   zero_threshold_r;
  logic [gci_pkg::THR_W-1:0]   right_threshold_r;

  logic [gci_pkg::AXES-1:0][gci_pkg::ACC_W-1:0]  accel;
  logic [gci_pkg::AXES-1:0][gci_pkg::RATE_W-1:0] rate;

  logic             s1_valid, s1_ready;
  gci_pkg::sample_t s1_sample;
  logic             s2_valid, s2_ready;
  gci_pkg::update_t s2_update;
  gci_pkg::result_t result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      still_min_sq_r    <= gci_pkg::STILL_MIN_SQ_RST;
      still_max_sq_r    <= gci_pkg::STILL_MAX_SQ_RST;
      zero_threshold_r  <= gci_pkg::ZERO_THRESHOLD_RST;
      right_threshold_r <= gci_pkg::RIGHT_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gci_pkg::REG_STILL_MIN_SQ: begin
          still_min_sq_r <= cfg_data[gci_pkg::STILL_W-1:0];
        end
        gci_pkg::REG_STILL_MAX_SQ: begin
          still_max_sq_r <= cfg_data[gci_pkg::STILL_W-1:0];
        end
        gci_pkg::REG_ZERO_THRESHOLD: begin
          zero_threshold_r <= cfg_data[gci_pkg::THR_W-1:0];
        end
        gci_pkg::REG_RIGHT_THRESHOLD: begin
          right_threshold_r <= cfg_data[gci_pkg::THR_W-1:0];
        end
        default: begin
          still_min_sq_r <= still_min_sq_r;
        end
      endcase
    end
  end

  // Unpack the input item.
  always_comb begin
    for (int i = 0; i < gci_pkg::AXES; i++) begin
      accel[i] = in_tdata[i*gci_pkg::ACC_W +: gci_pkg::ACC_W];
      rate[i]  = in_tdata[(gci_pkg::AXES + i)*gci_pkg::RATE_W +: gci_pkg::RATE_W];
    end
  end

  gci_sample_stage u_sample (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (in_tvalid),
    .up_ready    (in_tready),
    .accel       (accel),
    .rate        (rate),
    .elapsed_us  (in_tdata[96 +: gci_pkg::DT_W]),
    .restart_cal (in_tuser),
    .down_ready  (s1_ready),
    .valid_o     (s1_valid),
    .sample_o    (s1_sample)
  );

  gci_update_stage u_update (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (s1_valid),
    .up_ready     (s1_ready),
    .sample_i     (s1_sample),
    .still_min_sq (still_min_sq_r),
    .still_max_sq (still_max_sq_r),
    .down_ready   (s2_ready),
    .valid_o      (s2_valid),
    .update_o     (s2_update)
  );

  gci_snap_stage u_snap (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .up_valid              (s2_valid),
    .up_ready              (s2_ready),
    .update_i              (s2_update),
    .zero_threshold        (zero_threshold_r),
    .right_angle_threshold (right_threshold_r),
    .down_ready            (out_tready),
    .valid_o               (out_tvalid),
    .result_o              (result)
  );

  // Pack the result item.
  assign out_tdata = {2'b00, result.snap[2], result.snap[1], result.snap[0]};
  assign out_tuser = {result.status.cal_done, result.status.motion_fault,
                      result.status.calibrating};

endmodule

// File: sim/gyro_calibrate_and_integrate_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for gyro_calibrate_and_integrate_top
// Drives IMU sample items through calibration and integration under several
// stillness bands and snap thresholds, and tracks the expected calibration
// state and angles to check every result item field by field. Both stream
// sides idle at random. A short stretch integrates full-scale rates against
// biases at the rate extremes.
// ---------------------------------------------------------------------------
module gyro_calibrate_and_integrate_top_tb;

  localparam longint ANGLE_HI = (longint'(1) << (gci_pkg::ANGLE_W - 1)) - 1;
  localparam longint ANGLE_LO = -ANGLE_HI - 1;
  localparam logic [gci_pkg::STILL_W-1:0] SQ_MAX = '1;
  localparam logic [gci_pkg::THR_W-1:0] THR_MAX = '1;
  localparam int ONE_G_SQ = 4096 * 4096;
  // Full-scale steps after the calibration at the rate extremes.
  localparam int FULL_STEPS = 40;

  // One input item; accel_x sits in the lowest bits, as on in_tdata.
  typedef struct packed {
    logic                                          restart_cal;
    logic [gci_pkg::DT_W-1:0]                      elapsed_us;
    logic [gci_pkg::AXES-1:0][gci_pkg::RATE_W-1:0] rate;
    logic [gci_pkg::AXES-1:0][gci_pkg::ACC_W-1:0]  accel;
  } imu_sample_t;

  // One result item as seen on out_tuser and out_tdata.
  typedef struct packed {
    logic                                          calibrating;
    logic                                          motion_fault;
    logic                                          cal_done;
    logic [1:0]                                    pad;
    logic [gci_pkg::AXES-1:0][gci_pkg::SNAP_W-1:0] snap;
  } gyro_report_t;

  // Tracks calibration and angle state and holds the awaited results.
  class gyro_tracker;
    logic [gci_pkg::STILL_W-1:0] min_sq;
    logic [gci_pkg::STILL_W-1:0] max_sq;
    logic [gci_pkg::THR_W-1:0]   zero_thr;
    logic [gci_pkg::THR_W-1:0]   right_thr;
    bit                          cal_mode;
    int                          still_count;
    longint                      rate_sum [gci_pkg::AXES];
    longint                      bias [gci_pkg::AXES];
    longint                      angle [gci_pkg::AXES];
    gyro_report_t                awaited [$];
    int                          mismatches;

    function new();
      min_sq = gci_pkg::STILL_MIN_SQ_RST;
      max_sq = gci_pkg::STILL_MAX_SQ_RST;
      zero_thr = gci_pkg::ZERO_THRESHOLD_RST;
      right_thr = gci_pkg::RIGHT_THRESHOLD_RST;
      for (int i = 0; i < gci_pkg::AXES; i++)
        bias[i] = 0;
      restart_run();
      mismatches = 0;
    endfunction

    function void restart_run();
      cal_mode = 1'b1;
      still_count = 0;
      for (int i = 0; i < gci_pkg::AXES; i++) begin
        rate_sum[i] = 0;
        angle[i] = 0;
      end
    endfunction

    function void write_reg(logic [gci_pkg::CFG_IDX_W-1:0] idx,
                            logic [gci_pkg::CFG_W-1:0] data);
      case (idx)
        gci_pkg::REG_STILL_MIN_SQ:    min_sq = data[gci_pkg::STILL_W-1:0];
        gci_pkg::REG_STILL_MAX_SQ:    max_sq = data[gci_pkg::STILL_W-1:0];
        gci_pkg::REG_ZERO_THRESHOLD:  zero_thr = data[gci_pkg::THR_W-1:0];
        gci_pkg::REG_RIGHT_THRESHOLD: right_thr = data[gci_pkg::THR_W-1:0];
        default: ;
      endcase
    endfunction

    // Zero below and inside the band between the thresholds, signed right angle above it.
    function logic [gci_pkg::SNAP_W-1:0] snap_code(longint a);
      longint m;
      m = (a < 0) ? -a : a;
      if (a == 0 || m < longint'(zero_thr))
        return gci_pkg::SNAP_ZERO;
      if (m > longint'(right_thr))
        return (a < 0) ? gci_pkg::SNAP_NEG : gci_pkg::SNAP_POS;
      return gci_pkg::SNAP_ZERO;
    endfunction

    // Applies one accepted item to the state and queues its result.
    function void take_sample(imu_sample_t s);
      gyro_report_t e;
      longint a;
      longint mag;
      longint v;
      e = '0;
      if (s.restart_cal) begin
        restart_run();
      end else if (cal_mode) begin
        mag = 0;
        for (int i = 0; i < gci_pkg::AXES; i++) begin
          a = longint'($signed(s.accel[i]));
          mag += a * a;
        end
        if (mag > longint'(min_sq) && mag < longint'(max_sq)) begin
          for (int i = 0; i < gci_pkg::AXES; i++)
            rate_sum[i] += longint'($signed(s.rate[i]));
          still_count++;
          if (still_count >= gci_pkg::CAL_SAMPLES) begin
            for (int i = 0; i < gci_pkg::AXES; i++) begin
              bias[i] = rate_sum[i] / gci_pkg::CAL_SAMPLES;
              angle[i] = 0;
            end
            cal_mode = 1'b0;
            e.cal_done = 1'b1;
          end
        end else begin
          restart_run();
          e.motion_fault = 1'b1;
        end
      end else begin
        for (int i = 0; i < gci_pkg::AXES; i++) begin
          v = angle[i] + (longint'($signed(s.rate[i])) - bias[i]) * longint'(s.elapsed_us);
          if (v > ANGLE_HI)
            v = ANGLE_HI;
          if (v < ANGLE_LO)
            v = ANGLE_LO;
          angle[i] = v;
        end
      end
      e.calibrating = cal_mode;
      for (int i = 0; i < gci_pkg::AXES; i++)
        e.snap[i] = snap_code(angle[i]);
      awaited.push_back(e);
    endfunction

    // One line per mismatch; the count decides the verdict.
    task report(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task match_result(gyro_report_t got);
      gyro_report_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result %h with none awaited", got));
        return;
      end
      want = awaited.pop_front();
      if (got.calibrating !== want.calibrating)
        report($sformatf("calibrating %b, want %b", got.calibrating, want.calibrating));
      if (got.motion_fault !== want.motion_fault)
        report($sformatf("motion_fault %b, want %b", got.motion_fault, want.motion_fault));
      if (got.cal_done !== want.cal_done)
        report($sformatf("cal_done %b, want %b", got.cal_done, want.cal_done));
      if (got.pad !== 2'b00)
        report($sformatf("padding bits %b, want 00", got.pad));
      for (int i = 0; i < gci_pkg::AXES; i++)
        if (got.snap[i] !== want.snap[i])
          report($sformatf("snap axis %0d %b, want %b", i, got.snap[i], want.snap[i]));
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [111:0]                  in_tdata;
  logic                          in_tuser;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [7:0]                    out_tdata;
  logic [2:0]                    out_tuser;
  logic                          cfg_we;
  logic [gci_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gci_pkg::CFG_W-1:0]     cfg_data;

  gyro_tracker  sb = new();
  gyro_report_t seen;
  int           sent_count = 0;
  bit           tx_idle = 1'b1;
  bit           rx_idle = 1'b1;
  bit           exact_still = 1'b0;

  gyro_calibrate_and_integrate_top dut (.*);

  always #5 clk = ~clk;

  // Result side: random stall before each item, none when rx_idle is low.
  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = rx_idle ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Every accepted result is checked against the oldest awaited one.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.calibrating = out_tuser[0];
      seen.motion_fault = out_tuser[1];
      seen.cal_done = out_tuser[2];
      seen.pad = out_tdata[7:6];
      seen.snap = out_tdata[5:0];
      sb.match_result(seen);
    end
  end

  // Watchdog.
  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic imu_sample_t noise_sample();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[112:0];
  endfunction

  function automatic imu_sample_t mk(int ax, int ay, int az, int rx, int ry, int rz,
                                     int dt, bit rs);
    imu_sample_t s;
    s.accel[0] = 16'(ax);
    s.accel[1] = 16'(ay);
    s.accel[2] = 16'(az);
    s.rate[0] = 16'(rx);
    s.rate[1] = 16'(ry);
    s.rate[2] = 16'(rz);
    s.elapsed_us = 16'(dt);
    s.restart_cal = rs;
    return s;
  endfunction

  function automatic logic [gci_pkg::RATE_W-1:0] rate_near(int center, int spread);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767)
      v = 32767;
    if (v < -32768)
      v = -32768;
    return v[gci_pkg::RATE_W-1:0];
  endfunction

  // About 1 g along one random axis: exact, or with a small jitter that
  // stays inside the reset band.
  function automatic imu_sample_t still_sample(
    logic [gci_pkg::AXES-1:0][gci_pkg::RATE_W-1:0] rates
  );
    imu_sample_t s;
    bit exact;
    int major;
    int mag;
    s = noise_sample();
    s.restart_cal = 1'b0;
    s.rate = rates;
    exact = exact_still || ($urandom_range(0, 1) == 1);
    major = $urandom_range(0, gci_pkg::AXES - 1);
    mag = exact ? 4096 : 4096 + int'($urandom_range(0, 40)) - 20;
    for (int i = 0; i < gci_pkg::AXES; i++)
      s.accel[i] = exact ? 16'd0 : 16'(int'($urandom_range(0, 120)) - 60);
    s.accel[major] = ($urandom_range(0, 1) == 1) ? 16'(mag) : 16'(-mag);
    return s;
  endfunction

  task automatic send_sample(imu_sample_t s);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s[111:0];
    in_tuser <= s.restart_cal;
    do @(posedge clk); while (!in_tready);
    sb.take_sample(s);
    sent_count++;
  endtask

  // Hold the input side until every awaited result is back and the
  // pipeline has emptied.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.awaited.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(logic [gci_pkg::CFG_IDX_W-1:0] idx,
                         logic [gci_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic write_regs(logic [gci_pkg::STILL_W-1:0] lo_sq,
                            logic [gci_pkg::STILL_W-1:0] hi_sq,
                            logic [gci_pkg::THR_W-1:0] zero_thr,
                            logic [gci_pkg::THR_W-1:0] right_thr);
    wait_idle();
    cfg_put(gci_pkg::REG_STILL_MIN_SQ, gci_pkg::CFG_W'(lo_sq));
    cfg_put(gci_pkg::REG_STILL_MAX_SQ, gci_pkg::CFG_W'(hi_sq));
    cfg_put(gci_pkg::REG_ZERO_THRESHOLD, gci_pkg::CFG_W'(zero_thr));
    cfg_put(gci_pkg::REG_RIGHT_THRESHOLD, gci_pkg::CFG_W'(right_thr));
    cfg_we <= 1'b0;
  endtask

  // New thresholds, then an item with no elapsed time so the angles hold.
  task automatic probe_snap(logic [gci_pkg::THR_W-1:0] zero_thr,
                            logic [gci_pkg::THR_W-1:0] right_thr);
    write_regs(gci_pkg::STILL_W'(ONE_G_SQ - 1), gci_pkg::STILL_W'(ONE_G_SQ + 1),
               zero_thr, right_thr);
    send_sample(mk(-32768, 32767, -32768, 32767, -32768, 32767, 0, 0));
  endtask

  // A restart, a calibration run with rare movement or restarts, then a
  // stretch of integration with random rates around the calibrated bias.
  task automatic run_episode(int target);
    int ctr [gci_pkg::AXES];
    int spread;
    int n;
    int j;
    imu_sample_t s;
    logic [gci_pkg::AXES-1:0][gci_pkg::RATE_W-1:0] r;
    tx_idle = ($urandom_range(0, 3) != 0);
    rx_idle = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < gci_pkg::AXES; i++)
      ctr[i] = int'($urandom_range(0, 65535)) - 32768;
    case ($urandom_range(0, 3))
      0: spread = 0;
      1: spread = 4;
      2: spread = 300;
      default: spread = 32767;
    endcase
    s = noise_sample();
    s.restart_cal = 1'b1;
    send_sample(s);
    while (sb.cal_mode && sent_count < target) begin
      j = $urandom_range(0, 999);
      if (j < 3) begin
        s = noise_sample();
        s.restart_cal = (j == 2);
      end else begin
        for (int i = 0; i < gci_pkg::AXES; i++)
          r[i] = rate_near(ctr[i], spread);
        s = still_sample(r);
      end
      send_sample(s);
    end
    if ($urandom_range(0, 7) == 0)
      wait_idle();
    n = $urandom_range(10, 120);
    for (j = 0; j < n && !sb.cal_mode && sent_count < target; j++) begin
      s = noise_sample();
      s.restart_cal = ($urandom_range(0, 99) == 0);
      for (int i = 0; i < gci_pkg::AXES; i++)
        if ($urandom_range(0, 4) != 0)
          s.rate[i] = rate_near(ctr[i], spread);
      case ($urandom_range(0, 9))
        0: s.elapsed_us = '0;
        1: s.elapsed_us = '1;
        default: ;
      endcase
      send_sample(s);
    end
  endtask

  task automatic run_phase(int n);
    int target;
    target = sent_count + n;
    while (sent_count < target)
      run_episode(target);
  endtask

  initial begin
    logic [gci_pkg::AXES-1:0][gci_pkg::RATE_W-1:0] r;
    logic [gci_pkg::THR_W-1:0] zt;
    imu_sample_t s;
    int k;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Restart and movement cases while calibrating, at reset settings.
    send_sample(mk(-32768, -32768, -32768, 32767, 32767, 32767, 65535, 1));
    send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768, 65535, 0));
    send_sample(mk(32767, 32767, 32767, 32767, -32768, 0, 0, 0));
    send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_sample(mk(0, 0, 4096, -32768, 32767, 5, 1234, 0));
    send_sample(mk(30, -40, -4100, 100, -100, 7, 9, 0));
    send_sample(mk(0, 0, 4096, 1, 1, 1, 1, 1));
    send_sample(mk(-4096, 0, 0, 2, 2, 2, 2, 0));
    send_sample(mk(4096, 4096, 0, 3, 3, 3, 3, 0));

    // Magnitude equal to either bound is not still.
    exact_still = 1'b1;
    write_regs(gci_pkg::STILL_W'(ONE_G_SQ), gci_pkg::STILL_W'(ONE_G_SQ + 1),
               gci_pkg::ZERO_THRESHOLD_RST, gci_pkg::RIGHT_THRESHOLD_RST);
    send_sample(mk(0, 4096, 0, 0, 0, 0, 0, 0));
    write_regs(gci_pkg::STILL_W'(ONE_G_SQ - 1), gci_pkg::STILL_W'(ONE_G_SQ),
               gci_pkg::ZERO_THRESHOLD_RST, gci_pkg::RIGHT_THRESHOLD_RST);
    send_sample(mk(0, -4096, 0, 0, 0, 0, 0, 0));
    write_regs(gci_pkg::STILL_W'(ONE_G_SQ - 1), gci_pkg::STILL_W'(ONE_G_SQ + 1),
               gci_pkg::ZERO_THRESHOLD_RST, gci_pkg::RIGHT_THRESHOLD_RST);

    // Sums of -199, -399 and 199 check truncation toward zero.
    for (k = 0; k < gci_pkg::CAL_SAMPLES; k++) begin
      r[0] = (k < gci_pkg::CAL_SAMPLES - 1) ? 16'hFFFF : 16'h0000;
      r[1] = (k < gci_pkg::CAL_SAMPLES - 1) ? 16'hFFFE : 16'hFFFF;
      r[2] = (k < gci_pkg::CAL_SAMPLES - 1) ? 16'h0001 : 16'h0000;
      send_sample(still_sample(r));
    end

    // Angles of +100, -100 and exactly zero; acceleration is ignored now.
    send_sample(mk(-32768, -32768, -32768, 1, -2, 0, 100, 0));
    probe_snap(100, 100);
    probe_snap(100, 99);
    probe_snap(101, 99);
    probe_snap(0, 0);
    probe_snap(THR_MAX, THR_MAX);
    probe_snap(0, THR_MAX);
    send_sample(mk(32767, 32767, 32767, 0, 0, 0, 0, 1));

    // Random episodes under several stillness bands and thresholds.
    exact_still = 1'b0;
    write_regs(gci_pkg::STILL_MIN_SQ_RST, gci_pkg::STILL_MAX_SQ_RST,
               gci_pkg::ZERO_THRESHOLD_RST, gci_pkg::RIGHT_THRESHOLD_RST);
    run_phase(320);
    write_regs(0, SQ_MAX, 0, 0);
    run_phase(220);
    exact_still = 1'b1;
    write_regs(gci_pkg::STILL_W'(ONE_G_SQ - 1), gci_pkg::STILL_W'(ONE_G_SQ + 1),
               THR_MAX, THR_MAX);
    run_phase(220);
    exact_still = 1'b0;
    write_regs(SQ_MAX, 0, gci_pkg::THR_W'($urandom), gci_pkg::THR_W'($urandom));
    run_phase(50);
    zt = gci_pkg::THR_W'($urandom_range(0, 2000000000));
    write_regs(gci_pkg::STILL_W'(ONE_G_SQ - $urandom_range(200000, 400000)),
               gci_pkg::STILL_W'(ONE_G_SQ + $urandom_range(200000, 400000)), zt,
               ($urandom_range(0, 1) == 1)
                 ? zt + gci_pkg::THR_W'($urandom_range(0, 2000000000))
                 : gci_pkg::THR_W'($urandom_range(0, 32'(zt))));
    run_phase(280);

    // Bias at the rate extremes, then full-scale steps that push x up
    // and y down at the largest product per item.
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    exact_still = 1'b1;
    write_regs(gci_pkg::STILL_MIN_SQ_RST, gci_pkg::STILL_MAX_SQ_RST,
               gci_pkg::ZERO_THRESHOLD_RST, gci_pkg::RIGHT_THRESHOLD_RST);
    send_sample(mk(0, 0, 0, 0, 0, 0, 0, 1));
    r[0] = 16'h8000;
    r[1] = 16'h7FFF;
    r[2] = 16'h0000;
    for (k = 0; k < gci_pkg::CAL_SAMPLES; k++)
      send_sample(still_sample(r));
    for (k = 0; k < FULL_STEPS; k++) begin
      s = noise_sample();
      s.restart_cal = 1'b0;
      s.rate[0] = 16'h7FFF;
      s.rate[1] = 16'h8000;
      s.elapsed_us = '1;
      send_sample(s);
    end
    send_sample(mk(0, 0, 0, 0, 0, 0, 0, 1));

    // Let the last results drain, with a bound, then report.
    in_tvalid <= 1'b0;
    for (k = 0; k < 5000 && sb.awaited.size() != 0; k++)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.awaited.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.awaited.size()));
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
